// ===== src/region_refinement_selector_unit_defines.svh =====
// Assertion helpers for the selector RTL file.
`ifndef REGION_REFINEMENT_SELECTOR_UNIT_DEFINES_SVH
`define REGION_REFINEMENT_SELECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RRSU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrsu assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define RRSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrsu assertion failed");

`endif

// ===== src/rrsu_pkg.sv =====
package rrsu_pkg;

  localparam int MAX_CANDIDATES = 16;
  localparam int ID_BITS        = 16;

  localparam int SCORE_W    = 24;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [16:0]        ONE_Q16   = 17'h10000;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 24'hFFFFFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_WEIGHT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPOCH_LOG2   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AGE_TIMEOUT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NO_REFINE    = 8'd3;

  localparam logic [15:0] DECAY_WEIGHT_RST = 16'd58982;
  localparam logic [4:0]  EPOCH_LOG2_RST   = 5'd5;
  localparam logic [15:0] AGE_TIMEOUT_RST  = 16'd32;

  // Refinement mode codes
  localparam logic [2:0] MODE_UNREFINED = 3'd0;
  localparam logic [2:0] MODE_INC_READ  = 3'd1;
  localparam logic [2:0] MODE_INC_WRITE = 3'd2;
  localparam logic [2:0] MODE_CMP_READ  = 3'd3;
  localparam logic [2:0] MODE_CMP_WRITE = 3'd4;
  localparam logic [2:0] MODE_NONE      = 3'd5;

  // Shared unit operations
  localparam logic DEC_OP_DECAY = 1'b0;
  localparam logic DEC_OP_MUL   = 1'b1;

  typedef struct packed {
    logic               start;
    logic               op;
    logic [15:0]        weight;
    logic [TIME_W-1:0]  age;
    logic [SCORE_W-1:0] score;
    logic [32:0]        a;
    logic [SCORE_W-1:0] b;
  } dec_req_t;

  typedef struct packed {
    logic        done;
    logic [56:0] prod;
  } dec_rsp_t;

endpackage

// ===== src/rrsu_req_if.sv =====
interface rrsu_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] candidate_id;
  logic        write_access;
  logic        covers_region;
  logic        identity_projection;

  modport source (output valid, mode, candidate_id, write_access, covers_region,
                  identity_projection, input ready);
  modport sink (input valid, mode, candidate_id, write_access, covers_region,
                identity_projection, output ready);
endinterface

// ===== src/rrsu_rsp_if.sv =====
interface rrsu_rsp_if;
  logic        valid;
  logic        ready;
  logic        changed;
  logic        refined_present;
  logic        refined_kind;
  logic [15:0] refined_ident;
  logic        drop_old_valid;
  logic [15:0] drop_old_id;
  logic [2:0]  mode_state;
  logic        table_full;

  modport source (output valid, changed, refined_present, refined_kind, refined_ident,
                  drop_old_valid, drop_old_id, mode_state, table_full, input ready);
  modport sink (input valid, changed, refined_present, refined_kind, refined_ident,
                drop_old_valid, drop_old_id, mode_state, table_full, output ready);
endinterface

// ===== src/rrsu_cfg_if.sv =====
interface rrsu_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rrsu_pkg::CFG_IDX_W-1:0]  index;
  logic [rrsu_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/rrsu_ram.sv =====
module rrsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rrsu_decay.sv =====
module rrsu_decay (
  input  logic               clk,
  input  logic               rst,
  input  rrsu_pkg::dec_req_t req,
  output rrsu_pkg::dec_rsp_t rsp
);

  localparam logic [2:0] D_IDLE = 3'd0;
  localparam logic [2:0] D_LOOP = 3'd1;
  localparam logic [2:0] D_RUPD = 3'd2;
  localparam logic [2:0] D_BSQ  = 3'd3;
  localparam logic [2:0] D_BUPD = 3'd4;
  localparam logic [2:0] D_PROD = 3'd5;
  localparam logic [2:0] D_DONE = 3'd6;

  logic [2:0]  dst;
  logic [32:0] opa;
  logic [23:0] opb;
  logic [15:0] bb;
  logic [31:0] age_r;
  logic [56:0] prod;
  logic [32:0] ma;
  logic [23:0] mb;

  // operand select for the single multiplier
  always_comb begin
    case (dst)
      D_LOOP: begin
        ma = opa;
        mb = {8'b0, bb};
      end
      D_BSQ: begin
        ma = {17'b0, bb};
        mb = {8'b0, bb};
      end
      default: begin
        ma = opa;
        mb = opb;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dst == D_LOOP || dst == D_BSQ || dst == D_PROD) begin
      prod <= {24'b0, ma} * {33'b0, mb};
    end
    if (rst) begin
      dst <= D_IDLE;
    end else begin
      case (dst)
        D_IDLE: begin
          if (req.start) begin
            if (req.op == rrsu_pkg::DEC_OP_MUL) begin
              opa <= req.a;
              opb <= req.b;
              dst <= D_PROD;
            end else begin
              opa   <= 33'(rrsu_pkg::ONE_Q16);
              opb   <= req.score;
              bb    <= req.weight;
              age_r <= req.age;
              dst   <= D_LOOP;
            end
          end
        end
        D_LOOP: begin
          // stop once the exponent is used up or the power hit zero
          if (age_r == 32'd0 || opa == 33'd0) begin
            dst <= D_PROD;
          end else if (age_r[0]) begin
            dst <= D_RUPD;
          end else begin
            dst <= D_BSQ;
          end
        end
        D_RUPD: begin
          opa <= {16'b0, prod[32:16]};
          dst <= D_BSQ;
        end
        D_BSQ: begin
          dst <= D_BUPD;
        end
        D_BUPD: begin
          bb    <= prod[31:16];
          age_r <= age_r >> 1;
          dst   <= D_LOOP;
        end
        D_PROD: begin
          dst <= D_DONE;
        end
        D_DONE: begin
          dst <= D_IDLE;
        end
        default: begin
          dst <= D_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = (dst == D_DONE);
  assign rsp.prod = prod;

endmodule

// ===== src/region_refinement_selector_unit.sv =====
// Region refinement selector.
// Channels: req carries one access (kind, candidate id, write/complete flags,
// identity flag); rsp returns exactly one result per access; cfg writes the
// four registers by index (0 decay weight, 1 epoch log2, 2 timeout,
// 3 no-refine). cfg and req are ready only while idle, and a pending cfg
// transaction holds req off for that cycle.
// One access is in flight at a time. An ignored access goes straight to the
// output, and a direct refinement makes one purge pass over the table. A
// tracked access first looks the candidate up; a miss then inserts it (after
// a purge when the miss counter forces one). A hit runs one decay, stores
// the new score and, at an epoch crossing, scans the table and decays each
// stale entry, then may look up the chosen entry, form up to 3 products and
// make a purge pass. The input is ready again once the result is loaded.
// Latency is set by the single shared multiplier and the one read port of
// the table RAM.
// Reset clears choice, counters and table valid bits, and returns mode and config to their reset values.
// A stalled rsp holds the finished result; the next access is taken
// after it has been handed off to the output register.
`include "region_refinement_selector_unit_defines.svh"

module region_refinement_selector_unit #(
  parameter int MAX_CANDIDATES = rrsu_pkg::MAX_CANDIDATES,
  parameter int ID_BITS        = rrsu_pkg::ID_BITS
) (
  input logic        clk,
  input logic        rst,
  rrsu_req_if.sink   req,
  rrsu_rsp_if.source rsp,
  rrsu_cfg_if.sink   cfg
);

  localparam int IW = $clog2(MAX_CANDIDATES);
  localparam int NW = $clog2(MAX_CANDIDATES + 1);
  localparam int EW = 1 + ID_BITS + 24 + 32;
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_CANDIDATES - 1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_PUR_RD  = 5'd1;
  localparam logic [4:0] S_PUR_EV  = 5'd2;
  localparam logic [4:0] S_FIND_RD = 5'd3;
  localparam logic [4:0] S_FIND_EV = 5'd4;
  localparam logic [4:0] S_TUPD    = 5'd5;
  localparam logic [4:0] S_DOM_RD  = 5'd6;
  localparam logic [4:0] S_DOM_EV  = 5'd7;
  localparam logic [4:0] S_DOM_UPD = 5'd8;
  localparam logic [4:0] S_DOMEND  = 5'd9;
  localparam logic [4:0] S_DOMYES  = 5'd10;
  localparam logic [4:0] S_CH_RD   = 5'd11;
  localparam logic [4:0] S_CH_EV   = 5'd12;
  localparam logic [4:0] S_H1      = 5'd13;
  localparam logic [4:0] S_H2      = 5'd14;
  localparam logic [4:0] S_H3      = 5'd15;
  localparam logic [4:0] S_H4      = 5'd16;
  localparam logic [4:0] S_INS     = 5'd17;
  localparam logic [4:0] S_WAIT    = 5'd18;
  localparam logic [4:0] S_FIN     = 5'd19;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_REFINE = 2'd1;
  localparam logic [1:0] ACT_TRACK  = 2'd2;

  logic [15:0] decay_weight;
  logic [4:0]  epoch_log2;
  logic [15:0] age_timeout;
  logic        no_refine;

  logic [2:0]         refine_mode;
  logic               chosen_valid;
  logic               chosen_kind;
  logic [ID_BITS-1:0] chosen_id;
  logic [31:0]        tc;
  logic [15:0]        miss_count;
  logic [MAX_CANDIDATES-1:0] entry_valid;

  logic [4:0]         st;
  logic [4:0]         ret;
  logic               kind_q;
  logic [ID_BITS-1:0] id_q;
  logic               cur_q;
  logic               changed_q;
  logic               drop_v;
  logic [ID_BITS-1:0] drop_id;
  logic               full_q;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      f_idx;
  logic [31:0]        f_last;
  logic [23:0]        s_q;
  logic               dom_q;
  logic [NW-1:0]      n_q;
  logic               rfound;
  logic [23:0]        ref_q;
  logic [56:0]        lhs_q;
  logic [23:0]        ins_score;
  logic               pur_ins;
  logic [56:0]        mres;
  logic [ID_BITS:0]   e_hdr;

  logic        out_valid;
  logic        out_changed;
  logic        out_present;
  logic        out_kind;
  logic [15:0] out_ident;
  logic        out_drop_v;
  logic [15:0] out_drop_id;
  logic [2:0]  out_mode;
  logic        out_full;

  rrsu_pkg::dec_req_t dreq;
  rrsu_pkg::dec_rsp_t drsp;

  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [EW-1:0] rdata;

  logic               rd_kind;
  logic [ID_BITS-1:0] rd_id;
  logic [23:0]        rd_score;
  logic [31:0]        rd_last;

  logic [ID_BITS-1:0] id_in;
  logic               is_ch;
  logic [1:0]         act;
  logic [2:0]         nm;
  logic [2:0]         nm_cw;
  logic [24:0]        sum25;
  logic [23:0]        s_new;
  logic [15:0]        miss_n;
  logic               idx_end;

  rrsu_decay u_decay (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  rrsu_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_CANDIDATES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx),
    .rdata (rdata)
  );

  assign rd_last  = rdata[31:0];
  assign rd_score = rdata[55:32];
  assign rd_id    = rdata[56 +: ID_BITS];
  assign rd_kind  = rdata[EW-1];

  assign id_in   = ID_BITS'(req.candidate_id);
  assign is_ch   = chosen_valid && (chosen_kind == req.mode) && (chosen_id == id_in);
  assign idx_end = (idx == IDX_LAST);
  assign miss_n  = miss_count + 16'd1;
  assign sum25   = {1'b0, mres[39:16]} + 25'(rrsu_pkg::ONE_Q16);
  assign s_new   = (sum25 > {1'b0, rrsu_pkg::SCORE_MAX}) ? rrsu_pkg::SCORE_MAX : sum25[23:0];

  // mode machine decision for the access at the input
  always_comb begin
    nm_cw = req.covers_region ?
            (req.write_access ? rrsu_pkg::MODE_CMP_WRITE : rrsu_pkg::MODE_CMP_READ) :
            (req.write_access ? rrsu_pkg::MODE_INC_WRITE : rrsu_pkg::MODE_INC_READ);
    nm  = nm_cw;
    act = ACT_NONE;
    case (refine_mode)
      rrsu_pkg::MODE_UNREFINED: begin
        act = ACT_REFINE;
      end
      rrsu_pkg::MODE_INC_READ: begin
        act = (req.covers_region || req.write_access) ? ACT_REFINE : ACT_TRACK;
      end
      rrsu_pkg::MODE_INC_WRITE: begin
        if (req.covers_region) begin
          act = ACT_REFINE;
        end else if (req.write_access) begin
          act = ACT_TRACK;
        end
      end
      rrsu_pkg::MODE_CMP_READ: begin
        if (req.covers_region) begin
          act = req.write_access ? ACT_REFINE : ACT_TRACK;
          nm  = rrsu_pkg::MODE_CMP_WRITE;
        end
      end
      rrsu_pkg::MODE_CMP_WRITE: begin
        if (req.covers_region && req.write_access) begin
          act = ACT_TRACK;
        end
      end
      default: begin
        act = ACT_NONE;
      end
    endcase
    if (no_refine || (req.mode && req.identity_projection)) begin
      act = ACT_NONE;
    end
  end

  // table write port
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = {kind_q, id_q, ins_score, tc};
    case (st)
      S_TUPD: begin
        we    = 1'b1;
        waddr = f_idx;
        wdata = {kind_q, id_q, s_new, tc};
      end
      S_DOM_UPD: begin
        we    = 1'b1;
        wdata = {e_hdr, mres[39:16], tc};
      end
      S_INS: begin
        we = !entry_valid[idx];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // a cfg transaction takes the idle cycle ahead of an access
  assign req.ready = (st == S_IDLE) && !cfg.valid;
  assign cfg.ready = (st == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      decay_weight <= rrsu_pkg::DECAY_WEIGHT_RST;
      epoch_log2   <= rrsu_pkg::EPOCH_LOG2_RST;
      age_timeout  <= rrsu_pkg::AGE_TIMEOUT_RST;
      no_refine    <= 1'b0;
      refine_mode  <= rrsu_pkg::MODE_UNREFINED;
      chosen_valid <= 1'b0;
      chosen_kind  <= 1'b0;
      chosen_id    <= '0;
      tc           <= 32'd0;
      miss_count   <= 16'd0;
      entry_valid  <= '0;
      out_valid    <= 1'b0;
      dreq.start   <= 1'b0;
    end else begin
      // drop the start pulse once the shared unit has seen it
      if (st == S_WAIT) begin
        dreq.start <= 1'b0;
      end
      if (rsp.valid && rsp.ready && (st != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            kind_q    <= req.mode;
            id_q      <= id_in;
            cur_q     <= is_ch;
            changed_q <= 1'b0;
            drop_v    <= 1'b0;
            drop_id   <= '0;
            full_q    <= 1'b0;
            idx       <= '0;
            pur_ins   <= 1'b0;
            case (act)
              ACT_REFINE: begin
                refine_mode <= nm;
                if (!is_ch) begin
                  changed_q <= 1'b1;
                  if (chosen_valid && !chosen_kind) begin
                    drop_v  <= 1'b1;
                    drop_id <= chosen_id;
                  end
                  chosen_valid <= 1'b1;
                  chosen_kind  <= req.mode;
                  chosen_id    <= id_in;
                end
                st <= S_PUR_RD;
              end
              ACT_TRACK: begin
                tc <= tc + 32'd1;
                st <= S_FIND_RD;
              end
              default: begin
                st <= S_FIN;
              end
            endcase
          end
        end
        S_PUR_RD: begin
          st <= S_PUR_EV;
        end
        S_PUR_EV: begin
          if (entry_valid[idx] && ((tc - rd_last) > {16'b0, age_timeout})) begin
            entry_valid[idx] <= 1'b0;
          end
          if (idx_end) begin
            idx <= '0;
            st  <= pur_ins ? S_INS : S_FIN;
          end else begin
            idx <= idx + 1'b1;
            st  <= S_PUR_RD;
          end
        end
        S_FIND_RD: begin
          st <= S_FIND_EV;
        end
        S_FIND_EV: begin
          if (entry_valid[idx] && rd_kind == kind_q && rd_id == id_q) begin
            f_idx       <= idx;
            f_last      <= rd_last;
            dreq.start  <= 1'b1;
            dreq.op     <= rrsu_pkg::DEC_OP_DECAY;
            dreq.weight <= decay_weight;
            dreq.age    <= tc - rd_last;
            dreq.score  <= rd_score;
            ret         <= S_TUPD;
            st          <= S_WAIT;
          end else if (idx_end) begin
            idx <= '0;
            if (cur_q) begin
              ins_score  <= 24'(rrsu_pkg::ONE_Q16);
              miss_count <= 16'd0;
              st         <= S_INS;
            end else begin
              ins_score <= 24'd0;
              if (miss_n == age_timeout) begin
                miss_count <= 16'd0;
                pur_ins    <= 1'b1;
                st         <= S_PUR_RD;
              end else begin
                miss_count <= miss_n;
                st         <= S_INS;
              end
            end
          end else begin
            idx <= idx + 1'b1;
            st  <= S_FIND_RD;
          end
        end
        S_WAIT: begin
          if (drsp.done) begin
            mres <= drsp.prod;
            st   <= ret;
          end
        end
        S_TUPD: begin
          s_q        <= s_new;
          miss_count <= 16'd0;
          idx        <= '0;
          dom_q      <= 1'b1;
          // dominance is checked only when this access crosses an epoch
          if ((f_last >> epoch_log2) != (tc >> epoch_log2)) begin
            st <= S_DOM_RD;
          end else begin
            st <= S_FIN;
          end
        end
        S_DOM_RD: begin
          st <= S_DOM_EV;
        end
        S_DOM_EV: begin
          if (entry_valid[idx] && rd_last != tc) begin
            e_hdr       <= rdata[EW-1:56];
            dreq.start  <= 1'b1;
            dreq.op     <= rrsu_pkg::DEC_OP_DECAY;
            dreq.weight <= decay_weight;
            dreq.age    <= tc - rd_last;
            dreq.score  <= rd_score;
            ret         <= S_DOM_UPD;
            st          <= S_WAIT;
          end else if (idx_end) begin
            st <= S_DOMEND;
          end else begin
            idx <= idx + 1'b1;
            st  <= S_DOM_RD;
          end
        end
        S_DOM_UPD: begin
          if (s_q < mres[39:16]) begin
            dom_q <= 1'b0;
          end
          if (idx_end) begin
            st <= S_DOMEND;
          end else begin
            idx <= idx + 1'b1;
            st  <= S_DOM_RD;
          end
        end
        S_DOMEND: begin
          idx    <= '0;
          n_q    <= '0;
          rfound <= 1'b0;
          if (!dom_q) begin
            st <= S_FIN;
          end else if (cur_q || !chosen_valid) begin
            st <= S_DOMYES;
          end else begin
            st <= S_CH_RD;
          end
        end
        S_CH_RD: begin
          st <= S_CH_EV;
        end
        S_CH_EV: begin
          n_q <= n_q + NW'(entry_valid[idx]);
          if (entry_valid[idx] && !rfound && rd_kind == chosen_kind && rd_id == chosen_id) begin
            rfound <= 1'b1;
            ref_q  <= rd_score;
          end
          if (idx_end) begin
            st <= S_H1;
          end else begin
            idx <= idx + 1'b1;
            st  <= S_CH_RD;
          end
        end
        S_H1: begin
          if (!rfound) begin
            st <= S_DOMYES;
          end else begin
            dreq.start <= 1'b1;
            dreq.op    <= rrsu_pkg::DEC_OP_MUL;
            dreq.a     <= 33'(n_q);
            dreq.b     <= ref_q;
            ret        <= S_H2;
            st         <= S_WAIT;
          end
        end
        S_H2: begin
          dreq.start <= 1'b1;
          dreq.op    <= rrsu_pkg::DEC_OP_MUL;
          dreq.a     <= mres[32:0];
          dreq.b     <= ref_q;
          ret        <= S_H3;
          st         <= S_WAIT;
        end
        S_H3: begin
          lhs_q      <= mres;
          dreq.start <= 1'b1;
          dreq.op    <= rrsu_pkg::DEC_OP_MUL;
          dreq.a     <= {9'b0, s_q};
          dreq.b     <= s_q;
          ret        <= S_H4;
          st         <= S_WAIT;
        end
        S_H4: begin
          // hysteresis: ref^2 * n < score^2
          st <= (lhs_q < {9'b0, mres[47:0]}) ? S_DOMYES : S_FIN;
        end
        S_DOMYES: begin
          if (!cur_q) begin
            changed_q <= 1'b1;
            if (chosen_valid && !chosen_kind) begin
              drop_v  <= 1'b1;
              drop_id <= chosen_id;
            end
            chosen_valid <= 1'b1;
            chosen_kind  <= kind_q;
            chosen_id    <= id_q;
          end
          idx     <= '0;
          pur_ins <= 1'b0;
          st      <= S_PUR_RD;
        end
        S_INS: begin
          if (!entry_valid[idx]) begin
            entry_valid[idx] <= 1'b1;
            st               <= S_FIN;
          end else if (idx_end) begin
            full_q <= 1'b1;
            st     <= S_FIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_changed <= changed_q;
            out_present <= chosen_valid;
            out_kind    <= chosen_valid & chosen_kind;
            out_ident   <= chosen_valid ? 16'(chosen_id) : 16'd0;
            out_drop_v  <= drop_v;
            out_drop_id <= 16'(drop_id);
            out_mode    <= refine_mode;
            out_full    <= full_q;
            st          <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          rrsu_pkg::REG_DECAY_WEIGHT: decay_weight <= cfg.data;
          rrsu_pkg::REG_EPOCH_LOG2:   epoch_log2   <= cfg.data[4:0];
          rrsu_pkg::REG_AGE_TIMEOUT:  age_timeout  <= cfg.data;
          rrsu_pkg::REG_NO_REFINE: begin
            no_refine <= cfg.data[0];
            if (cfg.data[0]) begin
              refine_mode <= rrsu_pkg::MODE_NONE;
            end
          end
          default: begin
            no_refine <= no_refine;
          end
        endcase
      end
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.changed         = out_changed;
  assign rsp.refined_present = out_present;
  assign rsp.refined_kind    = out_kind;
  assign rsp.refined_ident   = out_ident;
  assign rsp.drop_old_valid  = out_drop_v;
  assign rsp.drop_old_id     = out_drop_id;
  assign rsp.mode_state      = out_mode;
  assign rsp.table_full      = out_full;

  `RRSU_ASSERT_IMPL(a_start_waits, dreq.start, st == S_WAIT)
  `RRSU_ASSERT_IMPL(a_drop_on_change, rsp.valid && rsp.drop_old_valid, rsp.changed)
  `RRSU_ASSERT_IMPL(a_change_present, rsp.valid && rsp.changed, rsp.refined_present)
  `RRSU_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, !req.ready)

endmodule

// ===== tb/tb_region_refinement_selector_unit.sv =====
module tb_region_refinement_selector_unit;

  localparam int NUM_SLOTS   = 16;
  localparam int STALL_LIMIT = 40000;

  typedef struct packed {
    logic        changed;
    logic        present;
    logic        kind;
    logic [15:0] ident;
    logic        drop_valid;
    logic [15:0] drop_id;
    logic [2:0]  mstate;
    logic        full;
  } access_result_t;

  logic clk;
  logic rst;

  rrsu_req_if req ();
  rrsu_rsp_if rsp ();
  rrsu_cfg_if cfg ();

  region_refinement_selector_unit DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow state of the selector
  logic [15:0] sh_decay;
  logic [4:0]  sh_epoch;
  logic [15:0] sh_timeout;
  bit          sh_no_refine;
  logic [2:0]  sh_mode;
  bit          sel_valid;
  bit          sel_kind;
  logic [15:0] sel_id;
  int unsigned trav_count;
  logic [15:0] miss_run;
  bit          slot_valid [NUM_SLOTS];
  bit          slot_kind [NUM_SLOTS];
  logic [15:0] slot_id [NUM_SLOTS];
  int unsigned slot_score [NUM_SLOTS];
  int unsigned slot_last [NUM_SLOTS];
  bit          hit_drop_valid;
  logic [15:0] hit_drop_id;
  bit          hit_full;

  access_result_t pending_results[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  bit          no_gaps = 1'b0;

  function automatic longint unsigned weight_pow(int unsigned age);
    longint unsigned r;
    longint unsigned b;
    r = 65536;
    b = sh_decay;
    while (age != 0 && r != 0) begin
      if (age[0]) r = (r * b) >> 16;
      b = (b * b) >> 16;
      age = age >> 1;
    end
    return r;
  endfunction

  function automatic int unsigned decayed_score(int unsigned score, int unsigned age);
    longint unsigned p;
    p = (weight_pow(age) * longint'(score)) >> 16;
    return int'(p);
  endfunction

  function automatic void purge_stale();
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_valid[i] && (trav_count - slot_last[i]) > {16'd0, sh_timeout})
        slot_valid[i] = 1'b0;
  endfunction

  function automatic int find_slot(bit kind, logic [15:0] id);
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_valid[i] && slot_kind[i] == kind && slot_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void insert_slot(bit kind, logic [15:0] id, int unsigned score);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!slot_valid[i]) begin
        slot_valid[i] = 1'b1;
        slot_kind[i] = kind;
        slot_id[i] = id;
        slot_score[i] = score;
        slot_last[i] = trav_count;
        return;
      end
    end
    hit_full = 1'b1;
  endfunction

  function automatic bit is_selected(bit kind, logic [15:0] id);
    return sel_valid && sel_kind == kind && sel_id == id;
  endfunction

  function automatic bit dominates(int unsigned score, bit current);
    bit dom;
    int r;
    longint unsigned n;
    longint unsigned base;
    dom = 1'b1;
    n = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!slot_valid[i] || slot_last[i] == trav_count) continue;
      slot_score[i] = decayed_score(slot_score[i], trav_count - slot_last[i]);
      slot_last[i] = trav_count;
      if (score < slot_score[i]) dom = 1'b0;
    end
    if (!dom) return 1'b0;
    if (current || !sel_valid) return 1'b1;
    r = find_slot(sel_kind, sel_id);
    if (r < 0) return 1'b1;
    for (int i = 0; i < NUM_SLOTS; i++) n += slot_valid[i] ? 1 : 0;
    base = slot_score[r];
    return base * base * n < longint'(score) * longint'(score);
  endfunction

  function automatic bit select_refinement(bit kind, logic [15:0] id);
    bit chg;
    chg = !is_selected(kind, id);
    if (chg) begin
      if (sel_valid && sel_kind == 1'b0) begin
        hit_drop_valid = 1'b1;
        hit_drop_id = sel_id;
      end
      sel_valid = 1'b1;
      sel_kind = kind;
      sel_id = id;
    end
    purge_stale();
    return chg;
  endfunction

  function automatic bit track_candidate(bit kind, logic [15:0] id);
    int f;
    longint unsigned s;
    int unsigned prev_ep;
    int unsigned cur_ep;
    bit current;
    current = is_selected(kind, id);
    trav_count++;
    f = find_slot(kind, id);
    if (f >= 0) begin
      s = longint'(decayed_score(slot_score[f], trav_count - slot_last[f])) + 65536;
      if (s > 64'hFFFFFF) s = 64'hFFFFFF;
      slot_score[f] = int'(s);
      prev_ep = slot_last[f] >> sh_epoch;
      cur_ep = trav_count >> sh_epoch;
      slot_last[f] = trav_count;
      miss_run = 16'd0;
      if (prev_ep != cur_ep && dominates(int'(s), current)) begin
        if (!current) return select_refinement(kind, id);
        purge_stale();
      end
    end else if (current) begin
      insert_slot(kind, id, 65536);
      miss_run = 16'd0;
    end else begin
      miss_run = miss_run + 16'd1;
      if (miss_run == sh_timeout) begin
        purge_stale();
        miss_run = 16'd0;
      end
      insert_slot(kind, id, 0);
    end
    return 1'b0;
  endfunction

  function automatic logic [2:0] mode_after(bit c, bit w);
    if (c) return w ? rrsu_pkg::MODE_CMP_WRITE : rrsu_pkg::MODE_CMP_READ;
    return w ? rrsu_pkg::MODE_INC_WRITE : rrsu_pkg::MODE_INC_READ;
  endfunction

  function automatic bit apply_access(bit kind, logic [15:0] id, bit w, bit c);
    case (sh_mode)
      rrsu_pkg::MODE_UNREFINED: begin
        sh_mode = mode_after(c, w);
        return select_refinement(kind, id);
      end
      rrsu_pkg::MODE_INC_READ: begin
        if (c || w) begin
          sh_mode = mode_after(c, w);
          return select_refinement(kind, id);
        end
        return track_candidate(kind, id);
      end
      rrsu_pkg::MODE_INC_WRITE: begin
        if (c) begin
          sh_mode = mode_after(c, w);
          return select_refinement(kind, id);
        end
        if (!w) return 1'b0;
        return track_candidate(kind, id);
      end
      rrsu_pkg::MODE_CMP_READ: begin
        if (!c) return 1'b0;
        if (w) begin
          sh_mode = rrsu_pkg::MODE_CMP_WRITE;
          return select_refinement(kind, id);
        end
        return track_candidate(kind, id);
      end
      rrsu_pkg::MODE_CMP_WRITE: begin
        if (!w || !c) return 1'b0;
        return track_candidate(kind, id);
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic access_result_t predict_access(bit kind, logic [15:0] id, bit w, bit c,
                                                    bit ident);
    access_result_t res;
    bit chg;
    hit_drop_valid = 1'b0;
    hit_drop_id = 16'd0;
    hit_full = 1'b0;
    chg = 1'b0;
    if (!sh_no_refine && !(kind && ident)) chg = apply_access(kind, id, w, c);
    res.changed = chg;
    res.present = sel_valid;
    res.kind = sel_valid ? sel_kind : 1'b0;
    res.ident = sel_valid ? sel_id : 16'd0;
    res.drop_valid = hit_drop_valid;
    res.drop_id = hit_drop_id;
    res.mstate = sh_mode;
    res.full = hit_full;
    return res;
  endfunction

  task automatic send_access(bit kind, logic [15:0] id, bit w, bit c, bit ident);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.mode <= kind;
    req.candidate_id <= id;
    req.write_access <= w;
    req.covers_region <= c;
    req.identity_projection <= ident;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(predict_access(kind, id, w, c, ident));
  endtask

  task automatic write_register(logic [rrsu_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      rrsu_pkg::REG_DECAY_WEIGHT: sh_decay = value;
      rrsu_pkg::REG_EPOCH_LOG2:   sh_epoch = value[4:0];
      rrsu_pkg::REG_AGE_TIMEOUT:  sh_timeout = value;
      rrsu_pkg::REG_NO_REFINE: begin
        sh_no_refine = value[0];
        if (value[0]) sh_mode = rrsu_pkg::MODE_NONE;
      end
      default: ;
    endcase
  endtask

  task automatic set_tuning(logic [15:0] w, logic [15:0] ep, logic [15:0] tmo);
    write_register(rrsu_pkg::REG_DECAY_WEIGHT, w);
    write_register(rrsu_pkg::REG_EPOCH_LOG2, ep);
    write_register(rrsu_pkg::REG_AGE_TIMEOUT, tmo);
  endtask

  // Draw from a small pool so candidates recur; now and then a fresh id.
  task automatic random_accesses(int count, logic [2:0] phase, int pool_size);
    logic [15:0] pool [8];
    logic [15:0] id;
    bit kind, w, c, ident;
    for (int i = 0; i < 8; i++) pool[i] = $urandom_range(0, 65535);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 1);
      id = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                       : pool[$urandom_range(0, pool_size - 1)];
      ident = kind ? ($urandom_range(0, 11) == 0) : $urandom_range(0, 1);
      case (phase)
        rrsu_pkg::MODE_INC_READ: begin
          w = 1'b0;
          c = 1'b0;
        end
        rrsu_pkg::MODE_INC_WRITE: begin
          w = ($urandom_range(0, 3) != 0);
          c = 1'b0;
        end
        rrsu_pkg::MODE_CMP_READ: begin
          w = 1'b0;
          c = ($urandom_range(0, 4) != 0);
        end
        default: begin
          w = ($urandom_range(0, 3) != 0);
          c = ($urandom_range(0, 3) != 0);
        end
      endcase
      send_access(kind, id, w, c, ident);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_first_access();
    send_access(1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b1);
  endtask

  task automatic test_identity_ignored();
    send_access(1'b1, 16'h0000, 1'b1, 1'b1, 1'b1);
    send_access(1'b1, 16'hA5A5, 1'b0, 1'b0, 1'b1);
  endtask

  task automatic test_table_full();
    write_register(rrsu_pkg::REG_AGE_TIMEOUT, 16'hFFFF);
    for (int i = 0; i < 18; i++)
      send_access(i[0], 16'(i * 16'h0F0F + 1), 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_incomplete_read();
    set_tuning(16'd58982, 16'd0, 16'd8);
    random_accesses(150, rrsu_pkg::MODE_INC_READ, 3);
    set_tuning(16'd0, 16'd1, 16'd3);
    random_accesses(120, rrsu_pkg::MODE_INC_READ, 5);
    set_tuning(16'd65535, 16'd3, 16'd65535);
    random_accesses(150, rrsu_pkg::MODE_INC_READ, 8);
    set_tuning(16'd40000, 16'd16, 16'd1);
    random_accesses(100, rrsu_pkg::MODE_INC_READ, 4);
    set_tuning(16'd65000, 16'd2, 16'd0);
    random_accesses(120, rrsu_pkg::MODE_INC_READ, 4);
  endtask

  task automatic test_incomplete_write();
    set_tuning(16'd62000, 16'd0, 16'd12);
    send_access(1'b0, 16'h1234, 1'b1, 1'b0, 1'b0);
    random_accesses(200, rrsu_pkg::MODE_INC_WRITE, 4);
    set_tuning(16'd30000, 16'd31, 16'd20);
    random_accesses(150, rrsu_pkg::MODE_INC_WRITE, 6);
  endtask

  task automatic test_complete_read();
    set_tuning(16'd65535, 16'd1, 16'd40);
    send_access(1'b1, 16'h00FF, 1'b0, 1'b1, 1'b0);
    random_accesses(350, rrsu_pkg::MODE_CMP_READ, 5);
  endtask

  task automatic test_complete_write();
    set_tuning(16'd50000, 16'd0, 16'd6);
    send_access(1'b0, 16'hFF00, 1'b1, 1'b1, 1'b0);
    random_accesses(200, rrsu_pkg::MODE_CMP_WRITE, 4);
    set_tuning(16'd1, 16'd4, 16'd65535);
    random_accesses(150, rrsu_pkg::MODE_CMP_WRITE, 7);
  endtask

  task automatic test_no_refine();
    write_register(rrsu_pkg::REG_NO_REFINE, 16'd1);
    random_accesses(30, rrsu_pkg::MODE_CMP_WRITE, 4);
    write_register(rrsu_pkg::REG_NO_REFINE, 16'd0);
    random_accesses(30, rrsu_pkg::MODE_CMP_WRITE, 4);
  endtask

  task automatic check_field(string label, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, label, exp_v, act_v);
      error_count++;
    end
  endtask

  initial begin
    int stall;
    access_result_t exp_r;
    rsp.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual changed=%b mode=%0d",
                 $time, rsp.changed, rsp.mode_state);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("changed", 16'(exp_r.changed), 16'(rsp.changed));
        check_field("refined_present", 16'(exp_r.present), 16'(rsp.refined_present));
        check_field("refined_kind", 16'(exp_r.kind), 16'(rsp.refined_kind));
        check_field("refined_ident", exp_r.ident, rsp.refined_ident);
        check_field("drop_old_valid", 16'(exp_r.drop_valid), 16'(rsp.drop_old_valid));
        check_field("drop_old_id", exp_r.drop_id, rsp.drop_old_id);
        check_field("mode_state", 16'(exp_r.mstate), 16'(rsp.mode_state));
        check_field("table_full", 16'(exp_r.full), 16'(rsp.table_full));
      end
    end
  end

  // Count cycles with no transaction on any channel.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    sh_decay = rrsu_pkg::DECAY_WEIGHT_RST;
    sh_epoch = rrsu_pkg::EPOCH_LOG2_RST;
    sh_timeout = rrsu_pkg::AGE_TIMEOUT_RST;
    sh_no_refine = 1'b0;
    sh_mode = rrsu_pkg::MODE_UNREFINED;
    sel_valid = 1'b0;
    sel_kind = 1'b0;
    sel_id = 16'd0;
    trav_count = 0;
    miss_run = 16'd0;
    for (int i = 0; i < NUM_SLOTS; i++) slot_valid[i] = 1'b0;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.mode <= 1'b0;
    req.candidate_id <= 16'd0;
    req.write_access <= 1'b0;
    req.covers_region <= 1'b0;
    req.identity_projection <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.index <= rrsu_pkg::REG_DECAY_WEIGHT;
    cfg.data <= 16'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_access();
    test_identity_ignored();
    test_table_full();
    test_incomplete_read();
    test_incomplete_write();
    test_complete_read();
    test_complete_write();
    test_no_refine();

    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
